// ----- rtl/core/button_press_classifier_blinker_core_assert.svh -----
// assertion macros used by the checker file
`ifndef BUTTON_PRESS_CLASSIFIER_BLINKER_CORE_ASSERT_SVH
`define BUTTON_PRESS_CLASSIFIER_BLINKER_CORE_ASSERT_SVH

// same-cycle implication, disabled while reset is held
`define BPCB_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bpcb assertion failed");

// next-cycle implication, disabled while reset is held
`define BPCB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bpcb assertion failed");

// next-cycle implication that also watches the reset cycles
`define BPCB_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("bpcb assertion failed");

`endif

// ----- rtl/core/bpcb_pkg.sv -----
package bpcb_pkg;

    localparam int TICK_COUNT_WIDTH_DEF = 12;
    localparam int LONG_PRESS_W         = 12;
    localparam int CFG_DATA_W           = 12;
    localparam int CFG_ADDR_W           = 3;

    typedef enum logic [2:0] {
        PH_IDLE     = 3'd0,
        PH_DEBOUNCE = 3'd1,
        PH_HOLD     = 3'd2,
        PH_ON       = 3'd3,
        PH_OFF      = 3'd4,
        PH_RELEASE  = 3'd5
    } phase_t;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_DEBOUNCE_TICKS   = 3'd0,
        REG_LONG_PRESS_TICKS = 3'd1,
        REG_LONG_BLINK_COUNT = 3'd2,
        REG_LONG_BLINK_HALF  = 3'd3,
        REG_SHORT_BLINK_HALF = 3'd4,
        REG_TOP_LEVEL        = 3'd5
    } cfg_index_t;

    typedef struct packed {
        logic [7:0]              debounce_ticks;
        logic [LONG_PRESS_W-1:0] long_press_ticks;
        logic [3:0]              long_blink_count;
        logic [7:0]              long_blink_half;
        logic [7:0]              short_blink_half;
        logic [2:0]              top_level;
    } cfg_t;

    // packed so that led_on lands in bit 0 of tdata
    typedef struct packed {
        logic       sequence_busy;
        logic       calibrate_pulse;
        logic [2:0] setting_level;
        logic       led_on;
    } result_t;

    localparam cfg_t CFG_RESET = '{
        debounce_ticks:   8'd10,
        long_press_ticks: 12'd3000,
        long_blink_count: 4'd10,
        long_blink_half:  8'd50,
        short_blink_half: 8'd125,
        top_level:        3'd4
    };

endpackage

// ----- rtl/core/bpcb_cfg.sv -----
module bpcb_cfg
    import bpcb_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_addr)
                REG_DEBOUNCE_TICKS:   cfg_next.debounce_ticks   = cfg_wdata[7:0];
                REG_LONG_PRESS_TICKS: cfg_next.long_press_ticks = cfg_wdata[LONG_PRESS_W-1:0];
                REG_LONG_BLINK_COUNT: cfg_next.long_blink_count = cfg_wdata[3:0];
                REG_LONG_BLINK_HALF:  cfg_next.long_blink_half  = cfg_wdata[7:0];
                REG_SHORT_BLINK_HALF: cfg_next.short_blink_half = cfg_wdata[7:0];
                REG_TOP_LEVEL:        cfg_next.top_level        = cfg_wdata[2:0];
                default:              cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= CFG_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- rtl/core/bpcb_step.sv -----
module bpcb_step
    import bpcb_pkg::*;
#(
    parameter int TICK_COUNT_WIDTH = TICK_COUNT_WIDTH_DEF
) (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    in_accept,
    input  logic    button_level,
    input  cfg_t    cfg,
    output result_t res
);

    localparam int CMP_W = (TICK_COUNT_WIDTH > LONG_PRESS_W) ? TICK_COUNT_WIDTH : LONG_PRESS_W;
    localparam logic [TICK_COUNT_WIDTH-1:0] TICK_MAX = '1;

    phase_t                      phase_reg, phase_next;
    logic [TICK_COUNT_WIDTH-1:0] tick_reg, tick_next;
    logic [3:0]                  blinks_reg, blinks_next;
    logic [2:0]                  level_reg, level_next;
    logic                        last_btn_reg;
    logic                        long_mode_reg, long_mode_next;
    logic                        pulse;

    logic [TICK_COUNT_WIDTH-1:0] tick_inc;
    logic [CMP_W-1:0]            tick_inc_ext;
    logic [7:0]                  half;
    logic [3:0]                  blinks_dec;

    assign tick_inc     = (tick_reg == TICK_MAX) ? TICK_MAX : tick_reg + 1'b1;
    assign tick_inc_ext = CMP_W'(tick_inc);
    assign half         = long_mode_reg ? cfg.long_blink_half : cfg.short_blink_half;
    assign blinks_dec   = blinks_reg - 4'd1;

    // next state
    always_comb begin
        phase_next     = phase_reg;
        tick_next      = tick_reg;
        blinks_next    = blinks_reg;
        level_next     = level_reg;
        long_mode_next = long_mode_reg;
        pulse          = 1'b0;
        case (phase_reg)
            PH_IDLE: begin
                if (last_btn_reg && !button_level) begin
                    phase_next = PH_DEBOUNCE;
                    tick_next  = '0;
                end
            end
            PH_DEBOUNCE: begin
                tick_next = tick_inc;
                if (tick_inc_ext >= CMP_W'(cfg.debounce_ticks)) begin
                    phase_next = PH_HOLD;
                    tick_next  = '0;
                end
            end
            PH_HOLD: begin
                if (!button_level) begin
                    tick_next = tick_inc;
                    if (tick_inc_ext >= CMP_W'(cfg.long_press_ticks) || tick_inc == TICK_MAX) begin
                        pulse          = 1'b1;
                        long_mode_next = 1'b1;
                        tick_next      = '0;
                        blinks_next    = cfg.long_blink_count;
                        phase_next     = (cfg.long_blink_count != 4'd0) ? PH_ON : PH_RELEASE;
                    end
                end else begin
                    level_next     = (level_reg >= cfg.top_level) ? 3'd0 : level_reg + 3'd1;
                    long_mode_next = 1'b0;
                    tick_next      = '0;
                    blinks_next    = {1'b0, level_next} + 4'd1;
                    phase_next     = PH_ON;
                end
            end
            PH_ON: begin
                tick_next = tick_inc;
                if (tick_inc_ext >= CMP_W'(half)) begin
                    tick_next  = '0;
                    phase_next = PH_OFF;
                end
            end
            PH_OFF: begin
                tick_next = tick_inc;
                if (tick_inc_ext >= CMP_W'(half)) begin
                    tick_next   = '0;
                    blinks_next = blinks_dec;
                    phase_next  = (blinks_dec != 4'd0) ? PH_ON : PH_RELEASE;
                end
            end
            PH_RELEASE: begin
                if (button_level) begin
                    phase_next = PH_IDLE;
                    tick_next  = '0;
                end
            end
            default: begin
                phase_next = PH_IDLE;
                tick_next  = '0;
            end
        endcase
    end

    // result of this transaction
    always_comb begin
        res.led_on          = (phase_reg == PH_ON);
        res.setting_level   = level_next;
        res.calibrate_pulse = pulse;
        res.sequence_busy   = (phase_next != PH_IDLE);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_IDLE;
            tick_reg      <= '0;
            blinks_reg    <= '0;
            level_reg     <= '0;
            last_btn_reg  <= 1'b1;
            long_mode_reg <= 1'b0;
        end else if (in_accept) begin
            phase_reg     <= phase_next;
            tick_reg      <= tick_next;
            blinks_reg    <= blinks_next;
            level_reg     <= level_next;
            last_btn_reg  <= button_level;
            long_mode_reg <= long_mode_next;
        end
    end

endmodule

// ----- rtl/core/bpcb_skid.sv -----
module bpcb_skid
    import bpcb_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    in_valid,
    output logic    in_ready,
    input  result_t in_data,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_data
);

    logic    out_valid_reg, out_valid_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t out_data_reg, out_data_next;
    result_t skid_data_reg, skid_data_next;

    assign in_ready = !skid_valid_reg;

    always_comb begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (out_ready || !out_valid_reg) begin
            if (skid_valid_reg) begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end else begin
                out_valid_next = in_valid;
                out_data_next  = in_data;
            end
        end else if (in_valid && !skid_valid_reg) begin
            // output stalled, park the transaction
            skid_valid_next = 1'b1;
            skid_data_next  = in_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ----- rtl/core/button_press_classifier_blinker_core.sv -----
// each result is registered for m_tdata, first into the skid register if m_tready stalls
// throughput: one tick transaction per cycle while the skid register is empty (s_tready high)
// a two-entry output buffer keeps s_tready high while one result waits on m_tready
// reset: synchronous, active low; phase idle, counters and level zero, button seen released,
// registers back to their defaults and no result pending
module button_press_classifier_blinker_core
    import bpcb_pkg::*;
#(
    parameter int TICK_COUNT_WIDTH = TICK_COUNT_WIDTH_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,   // [0] button_level, [7:1] zero
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [7:0]            m_tdata,   // [0] led_on, [3:1] setting_level,
                                             // [4] calibrate_pulse, [5] sequence_busy, [7:6] zero
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    cfg_t    cfg;
    result_t step_res;
    result_t out_res;
    logic    in_accept;

    assign in_accept = s_tvalid && s_tready;

    bpcb_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    bpcb_step #(
        .TICK_COUNT_WIDTH (TICK_COUNT_WIDTH)
    ) u_step (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_accept    (in_accept),
        .button_level (s_tdata[0]),
        .cfg          (cfg),
        .res          (step_res)
    );

    bpcb_skid u_skid (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_data   (step_res),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_res)
    );

    assign m_tdata = {2'b00, out_res};

endmodule

// ----- rtl/core/bpcb_checker.sv -----
`include "button_press_classifier_blinker_core_assert.svh"

module bpcb_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata
);

    // nothing pending straight after reset
    `BPCB_ASSERT_NEXT_ALWAYS(a_idle_after_reset, aclk, !aresetn, !m_tvalid)

    // a stalled result holds
    `BPCB_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata))

    // input only backs up once the output register is full
    `BPCB_ASSERT_SAME(a_ready_backpressure, aclk, aresetn, !s_tready, m_tvalid)

    // calibrate tick comes out of the hold phase: led dark, sequence still running
    `BPCB_ASSERT_SAME(a_pulse_shape, aclk, aresetn, m_tvalid && m_tdata[4],
        !m_tdata[0] && m_tdata[5] && m_tdata[7:6] == 2'b00)

endmodule

bind button_press_classifier_blinker_core bpcb_checker u_bpcb_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
